// ----- rtl/hid_boot_report_to_key_events_assert.svh -----
// Assertion macros used by the HID boot report differencer controller.
`ifndef HID_BOOT_REPORT_TO_KEY_EVENTS_ASSERT_SVH
`define HID_BOOT_REPORT_TO_KEY_EVENTS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HBKE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HBKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hbke_pkg.sv -----
// Types, constants and helpers shared by the HID boot report differencer.
`default_nettype none
package hbke_pkg;

  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_W     = 3;
  localparam int MASK_W     = 18;
  localparam int IDX_W      = 5;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 4;

  // first modifier event position in the keyboard event mask
  localparam logic [IDX_W-1:0] MOD_BASE = 5'd12;

  localparam logic [7:0] ROLLOVER_CODE = 8'd1;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_MOTION  = 2'd2;

  localparam logic [1:0] SRC_KEY = 2'd0;
  localparam logic [1:0] SRC_MOD = 2'd1;
  localparam logic [1:0] SRC_BTN = 2'd2;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic pop;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic mask_empty;
    logic out_free;
  } sts_t;

  // Modifier events run over bits 0..4 and 6; bits 5 and 7 never report.
  function automatic logic [2:0] mod_bit(input logic [2:0] j);
    logic [2:0] b;
    case (j)
      3'd0: b = 3'd0;
      3'd1: b = 3'd1;
      3'd2: b = 3'd2;
      3'd3: b = 3'd3;
      3'd4: b = 3'd4;
      3'd5: b = 3'd6;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hbke_dp.sv -----
// Datapath: captured report, stored previous state, event mask and output register.
`default_nettype none
module hbke_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hbke_pkg::cmd_t                  cmd,
  output hbke_pkg::sts_t                       sts,
  input  wire logic                            in_mouse,
  input  wire logic [hbke_pkg::IN_DATA_W-1:0]  in_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [hbke_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [hbke_pkg::OUT_USER_W-1:0]      m_tuser,
  output logic                                 m_tlast
);
  import hbke_pkg::*;

  logic              cap_mouse;
  logic [7:0]        cap_mods;
  logic [7:0]        cap_keys [NUM_SLOTS];
  logic [2:0]        cap_btn;
  logic signed [7:0] cap_dx;
  logic signed [7:0] cap_dy;

  logic [7:0]        prev_mods;
  logic [7:0]        prev_keys [NUM_SLOTS];
  logic [2:0]        prev_btn;

  logic [MASK_W-1:0] mask;
  logic [MASK_W-1:0] mask_next;
  logic              rollover;
  logic              rollover_next;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [1:0]        out_src;
  logic [7:0]        out_code;
  logic signed [7:0] out_dx;
  logic signed [7:0] out_dy;
  logic              out_last;

  logic [MASK_W-1:0] low_bit;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_rel;
  logic [SLOT_W-1:0] slot;
  logic [2:0]        bit_sel;
  logic [1:0]        ev_kind;
  logic [1:0]        ev_src;
  logic [7:0]        ev_code;
  logic signed [7:0] ev_dx;
  logic signed [7:0] ev_dy;

  // Build the event mask from the captured report and the stored state.
  always_comb begin
    logic in_prev;
    logic in_cur;
    in_prev       = 1'b0;
    in_cur        = 1'b0;
    mask_next     = '0;
    rollover_next = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (cap_keys[i] != ROLLOVER_CODE) begin
        rollover_next = 1'b0;
      end
    end
    if (cap_mouse) begin
      rollover_next = 1'b0;
      mask_next[0]  = (cap_dx != 8'sd0) || (cap_dy != 8'sd0);
      for (int b = 0; b < 3; b++) begin
        mask_next[b+1] = cap_btn[b] ^ prev_btn[b];
      end
    end else if (!rollover_next) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        in_prev = 1'b0;
        in_cur  = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (prev_keys[k] == cap_keys[i]) begin
            in_prev = 1'b1;
          end
          if (cap_keys[k] == prev_keys[i]) begin
            in_cur = 1'b1;
          end
        end
        mask_next[2*i]   = (cap_keys[i] != 8'd0) && !in_prev;
        mask_next[2*i+1] = (prev_keys[i] != 8'd0) && !in_cur;
      end
      for (int j = 0; j < 6; j++) begin
        mask_next[int'(MOD_BASE)+j] = cap_mods[mod_bit(3'(j))] ^ prev_mods[mod_bit(3'(j))];
      end
    end
  end

  // Pick the lowest pending event and decode it.
  assign low_bit = mask & (~mask + MASK_W'(1));

  always_comb begin
    idx = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (low_bit[k]) begin
        idx = IDX_W'(k);
      end
    end
  end

  assign idx_rel = cap_mouse ? (idx - IDX_W'(1)) : (idx - MOD_BASE);
  assign slot    = idx[SLOT_W:1];
  assign bit_sel = cap_mouse ? idx_rel[2:0] : mod_bit(idx_rel[2:0]);

  always_comb begin
    ev_kind = EV_PRESS;
    ev_src  = SRC_KEY;
    ev_code = 8'd0;
    ev_dx   = 8'sd0;
    ev_dy   = 8'sd0;
    if (cap_mouse) begin
      if (idx == '0) begin
        ev_kind = EV_MOTION;
        ev_dx   = cap_dx;
        ev_dy   = cap_dy;
      end else begin
        ev_kind = cap_btn[bit_sel[1:0]] ? EV_PRESS : EV_RELEASE;
        ev_src  = SRC_BTN;
        ev_code = {5'd0, bit_sel};
      end
    end else if (idx < MOD_BASE) begin
      ev_kind = idx[0] ? EV_RELEASE : EV_PRESS;
      ev_code = idx[0] ? prev_keys[slot] : cap_keys[slot];
    end else begin
      ev_kind = cap_mods[bit_sel] ? EV_PRESS : EV_RELEASE;
      ev_src  = SRC_MOD;
      ev_code = {5'd0, bit_sel};
    end
  end

  // Capture the incoming report.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_mouse <= in_mouse;
      cap_mods  <= in_data[7:0];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cap_keys[i] <= in_data[8*i+8 +: 8];
      end
      cap_btn <= in_data[58:56];
      cap_dx  <= in_data[66:59];
      cap_dy  <= in_data[74:67];
    end
  end

  // Hold the mask; drop one event per pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      rollover <= 1'b0;
    end else if (cmd.evaluate) begin
      mask     <= mask_next;
      rollover <= rollover_next;
    end else if (cmd.pop) begin
      mask <= mask & ~low_bit;
    end
  end

  // Store the report once all its events are out, unless it was a keyboard rollover error.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods <= '0;
      prev_btn  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
    end else if (cmd.commit && !rollover) begin
      if (cap_mouse) begin
        prev_btn <= cap_btn;
      end else begin
        prev_mods <= cap_mods;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          prev_keys[i] <= cap_keys[i];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_kind <= ev_kind;
      out_src  <= ev_src;
      out_code <= ev_code;
      out_dx   <= ev_dx;
      out_dy   <= ev_dy;
      out_last <= (mask & ~low_bit) == '0;
    end
  end

  assign sts.mask_empty = (mask == '0);
  assign sts.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_dy, out_dx, out_code};
  assign m_tuser  = {out_src, out_kind};
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

// ----- rtl/hbke_ctrl.sv -----
// Controller: sequences capture, evaluation, event emission and state update.
`default_nettype none
module hbke_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output hbke_pkg::cmd_t      cmd,
  input  wire hbke_pkg::sts_t sts
);
  import hbke_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.mask_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready     = (state == ST_IDLE);
  assign cmd.capture  = (state == ST_IDLE) && s_tvalid;
  assign cmd.evaluate = (state == ST_EVAL);
  assign cmd.pop      = (state == ST_EMIT) && !sts.mask_empty && sts.out_free;
  assign cmd.commit   = (state == ST_EMIT) && sts.mask_empty;

`include "hid_boot_report_to_key_events_assert.svh"

  `HBKE_ASSERT_NEXT(a_accept_to_eval, cmd.capture, state == ST_EVAL, "accept did not start evaluation")
  `HBKE_ASSERT_NEXT(a_eval_to_emit, state == ST_EVAL, state == ST_EMIT, "evaluation did not lead to emission")
  `HBKE_ASSERT_NEXT(a_done_to_idle, cmd.commit, state == ST_IDLE && s_tready, "commit did not return to idle")

endmodule
`default_nettype wire

// ----- rtl/hid_boot_report_to_key_events.sv -----
// Top level of the HID boot report differencer: keyboard and mouse reports in, events out.
//
// Input channel s_*: one word per HID boot report. s_tuser selects the report
// kind (0 keyboard, 1 mouse); s_tdata carries all report fields.
// Output channel m_*: one word per event, with m_tlast on the final event of a
// report. A report that causes no event (no change, or a keyboard rollover
// error with all six slots at 1) produces no output word at all.
// Timing: the report is accepted, evaluated in the next cycle (all slot
// comparisons at once into an event mask), then the mask is drained one event
// per cycle into the output register while the receiver does not stall; a
// report yields at most 18 events for a keyboard, 4 for a mouse. The drain
// loop is the rate limiter.
// s_tready is high only while no report is in progress; the last event may
// still wait in the output register while the next report is taken.
// Reset clears the stored previous keys, modifiers and buttons to zero and
// empties the output register; a stalled receiver simply holds the drain.
`default_nettype none
module hid_boot_report_to_key_events (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] modifiers, [15:8] key_1, [23:16] key_2, [31:24] key_3,
  // [39:32] key_4, [47:40] key_5, [55:48] key_6, [58:56] mouse_buttons,
  // [66:59] move_x, [74:67] move_y, [79:75] zero
  input  wire logic [79:0] s_tdata,
  // [0] report kind: 0 keyboard, 1 mouse
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] code, [15:8] delta_x, [23:16] delta_y
  output logic [23:0]      m_tdata,
  // [1:0] event_kind, [3:2] source
  output logic [3:0]       m_tuser,
  // last
  output logic             m_tlast
);
  import hbke_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the report through capture, evaluate, drain and store.
  hbke_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hold the report, compare it with the stored one, and register each event.
  hbke_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_mouse (s_tuser),
    .in_data  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
